// ----- src/idscl_pkg.sv -----
// Package for the insertion/deletion/substitution channel likelihood block.
// Holds the lattice sizes, fixed-point constants, register map, state type
// and the Q1.31 helper functions. Depends on nothing.
package idscl_pkg;

    // Lattice geometry. These values settle the field widths of the stream.
    localparam int BETA      = 4;
    localparam int MAX_RECV  = 2 * BETA;
    localparam int COLS      = MAX_RECV + 1;
    localparam int RAM_DEPTH = 2 * COLS;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int ROW_W     = $clog2(BETA + 1);
    localparam int ROW_IW    = (BETA > 1) ? $clog2(BETA) : 1;
    localparam int COL_W     = $clog2(MAX_RECV + 3);
    localparam int RECV_IW   = (MAX_RECV > 1) ? $clog2(MAX_RECV) : 1;
    localparam int SYM_W     = 2;
    localparam int SENT_W    = SYM_W * BETA;
    localparam int RECV_W    = SYM_W * MAX_RECV;
    localparam int LEN_W     = 4;
    localparam int APB_AW    = 4;

    // Fixed-point constants.
    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
    localparam logic [31:0] RECIP3  = 32'hAAAA_AAAB;   // ceil(2^33 / 3)
    localparam logic [14:0] PID_MAX = 15'd16384;
    localparam logic [15:0] PS_MAX  = 16'd32768;

    // Register map, word index taken from paddr[3:2].
    localparam logic [1:0] REG_INDEL  = 2'd0;
    localparam logic [1:0] REG_SUBST  = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;

    localparam logic [14:0] INDEL_RST  = 15'd328;
    localparam logic [15:0] SUBST_RST  = 16'd328;
    localparam logic [31:0] THRESH_RST = 32'd21475;

    // Last step of the per-item constant setup.
    localparam logic [3:0] PRE_LAST = 4'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_ACC1,
        ST_ACC2,
        ST_OUT
    } t_state;

    // Q1.31 product taken from a full 64-bit product.
    function automatic logic [31:0] q31(input logic [63:0] prod);
        return prod[62:31];
    endfunction

    // Q1.31 sum that saturates at one.
    function automatic logic [31:0] qadd(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, ONE_Q31}) ? ONE_Q31 : s[31:0];
    endfunction

endpackage

// ----- src/idscl_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered. Depends on nothing.
module idscl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 18,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ids_channel_likelihood.sv -----
// Top level of the insertion/deletion/substitution channel likelihood block.
// Uses idscl_pkg and the lattice row memory idscl_ram.
//
// Usage:
//   The slave stream takes one beat per word pair: s_axis_tdata holds
//   sent_symbols, recv_symbols and recv_length. The master stream returns
//   one beat per input beat: m_axis_tdata is the likelihood in unsigned
//   Q1.31, m_axis_tuser is set when it reaches keep_threshold.
//   The APB port holds indel_prob (0x0), subst_prob (0x4) and
//   keep_threshold (0x8); write them only while no beat is in flight.
//   Each beat first forms the per-word score products, then walks the
//   lattice row by row with one shared 32x32 multiplier over
//   BETA*(recv_length+1) cells, and finally loads the result into the
//   output register. A beat with recv_length above 8 skips the lattice
//   and goes straight to the output register.
//   One word is worked on at a time; the next beat is taken as soon as the
//   result sits in the output register, even if the receiver stalls.
//   Two lattice rows live in the RAM, alternating banks; the bottom row is
//   generated on the fly and needs no fill. Reset returns the registers to
//   their defaults and drops any beat in flight.
module ids_channel_likelihood
    import idscl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // APB configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,  // sent_symbols[7:0], recv_symbols[23:8],
                                             // recv_length[27:24], zero pad
    // Output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,  // likelihood[31:0]
    output logic              m_axis_tuser   // above_threshold[0]
);

    t_state r_state, n_state;

    logic [14:0]       r_indel;
    logic [15:0]       r_subst;
    logic [31:0]       r_thresh;

    logic [SENT_W-1:0] r_sent;
    logic [RECV_W-1:0] r_recv;
    logic [LEN_W-1:0]  r_len;

    logic [3:0]        r_step;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;

    logic [63:0]       r_prod;
    logic [31:0]       r_acc;
    logic [31:0]       r_mis;
    logic [31:0]       r_pass_m, r_pass_x;
    logic [31:0]       r_ins_m, r_ins_x;
    logic [31:0]       r_ins_mm, r_ins_mx, r_ins_xm, r_ins_xx;

    logic              r_m_tvalid;
    logic [31:0]       r_m_tdata;
    logic              r_m_tuser;

    logic              s_accept;
    logic              cfg_write;
    logic              out_load;

    logic [14:0]       pid_c;
    logic [15:0]       ps_c;
    logic [31:0]       pid31, ptrn31, ps31, match31;

    logic [SYM_W-1:0]  sent_syms [BETA];
    logic [SYM_W-1:0]  recv_syms [MAX_RECV];
    logic [SYM_W-1:0]  x_sym, y0_sym, y1_sym;
    logic              s0_match, s1_match;
    logic [COL_W-1:0]  col1, col2, len_c;
    logic              last_col, pass_ok, ins_ok;

    logic [31:0]       mul_a, mul_b;
    logic [31:0]       pass_sel, ins_sel;
    logic [31:0]       lat_val, cell_final;
    logic [COL_W-1:0]  rd_col, rd_clamp, data_col;
    logic              rd_bank;

    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]       ram_rdata;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_indel  <= INDEL_RST;
            r_subst  <= SUBST_RST;
            r_thresh <= THRESH_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_INDEL:  r_indel  <= pwdata[14:0];
                REG_SUBST:  r_subst  <= pwdata[15:0];
                REG_THRESH: r_thresh <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_INDEL:  prdata = {17'd0, r_indel};
            REG_SUBST:  prdata = {16'd0, r_subst};
            REG_THRESH: prdata = r_thresh;
            default:    prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Probabilities in Q1.31
    // ------------------------------------------------------------------
    assign pid_c   = (r_indel > PID_MAX) ? PID_MAX : r_indel;
    assign ps_c    = (r_subst > PS_MAX) ? PS_MAX : r_subst;
    assign pid31   = {1'b0, pid_c, 16'd0};
    assign ptrn31  = ONE_Q31 - {pid31[30:0], 1'b0};
    assign ps31    = {ps_c, 16'd0};
    assign match31 = ONE_Q31 - ps31;

    // ------------------------------------------------------------------
    // Symbol compare for the current cell
    // ------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < BETA; k++) begin
            sent_syms[k] = r_sent[k*SYM_W +: SYM_W];
        end
        for (int k = 0; k < MAX_RECV; k++) begin
            recv_syms[k] = r_recv[k*SYM_W +: SYM_W];
        end
    end

    assign col1  = r_col + COL_W'(1);
    assign col2  = r_col + COL_W'(2);
    assign len_c = COL_W'(r_len);

    // Received indexes past the word only feed terms that are discarded.
    assign x_sym    = sent_syms[r_row[ROW_IW-1:0]];
    assign y0_sym   = recv_syms[r_col[RECV_IW-1:0]];
    assign y1_sym   = recv_syms[col1[RECV_IW-1:0]];
    assign s0_match = (x_sym == y0_sym);
    assign s1_match = (x_sym == y1_sym);

    // Columns run from the word end down to zero, so the last cell of the
    // top row is the result.
    assign last_col = (r_col == '0);
    assign pass_ok  = (r_col < len_c);
    assign ins_ok   = (col1 < len_c);

    assign pass_sel = s0_match ? r_pass_m : r_pass_x;
    always_comb begin
        case ({s0_match, s1_match})
            2'b11:   ins_sel = r_ins_mm;
            2'b10:   ins_sel = r_ins_mx;
            2'b01:   ins_sel = r_ins_xm;
            default: ins_sel = r_ins_xx;
        endcase
    end

    // ------------------------------------------------------------------
    // Lattice row memory: row i sits in bank i[0], row i+1 is read back.
    // ------------------------------------------------------------------
    always_comb begin
        case (r_state)
            ST_RD1:  rd_col = col1;
            ST_RD2:  rd_col = col2;
            default: rd_col = r_col;
        endcase
        case (r_state)
            ST_RD2:  data_col = col1;
            ST_ACC1: data_col = col2;
            default: data_col = r_col;
        endcase
    end

    assign rd_bank   = ~r_row[0];
    assign rd_clamp  = (rd_col > COL_W'(MAX_RECV)) ? COL_W'(MAX_RECV) : rd_col;
    assign ram_raddr = rd_bank ? (RAM_AW'(COLS) + RAM_AW'(rd_clamp)) : RAM_AW'(rd_clamp);
    assign ram_waddr = r_row[0] ? (RAM_AW'(COLS) + RAM_AW'(r_col)) : RAM_AW'(r_col);

    // The row below the last transmitted symbol is one at the word end, zero elsewhere.
    always_comb begin
        if (r_row == ROW_W'(BETA - 1)) begin
            lat_val = (data_col == len_c) ? ONE_Q31 : 32'd0;
        end else begin
            lat_val = ram_rdata;
        end
    end

    assign cell_final = ins_ok ? qadd(r_acc, q31(r_prod)) : r_acc;

    idscl_ram #(
        .WIDTH (32),
        .DEPTH (RAM_DEPTH)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (cell_final),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid & s_axis_tready;
    assign out_load      = (r_state == ST_OUT) && (!r_m_tvalid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_axis_tdata[27:24] > LEN_W'(MAX_RECV)) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_PRE;
                    end
                end
            end
            ST_PRE: begin
                if (r_step == PRE_LAST) begin
                    n_state = ST_RD0;
                end
            end
            ST_RD0:  n_state = ST_RD1;
            ST_RD1:  n_state = ST_RD2;
            ST_RD2:  n_state = ST_ACC1;
            ST_ACC1: n_state = ST_ACC2;
            ST_ACC2: begin
                if (last_col && (r_row == '0)) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_RD0;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Multiplier operands and memory write enable.
    always_comb begin
        mul_a  = 32'd0;
        mul_b  = 32'd0;
        ram_we = 1'b0;
        case (r_state)
            ST_PRE: begin
                case (r_step)
                    4'd0: begin mul_a = ps31;    mul_b = RECIP3;  end
                    4'd1: begin mul_a = pid31;   mul_b = match31; end
                    4'd2: begin mul_a = ptrn31;  mul_b = r_mis;   end
                    4'd3: begin mul_a = pid31;   mul_b = r_mis;   end
                    4'd4: begin mul_a = ptrn31;  mul_b = match31; end
                    4'd5: begin mul_a = r_ins_m; mul_b = match31; end
                    4'd6: begin mul_a = r_ins_m; mul_b = r_mis;   end
                    4'd7: begin mul_a = r_ins_x; mul_b = match31; end
                    4'd8: begin mul_a = r_ins_x; mul_b = r_mis;   end
                    default: ;
                endcase
            end
            ST_RD1:  begin mul_a = pid31;    mul_b = lat_val; end
            ST_RD2:  begin mul_a = pass_sel; mul_b = lat_val; end
            ST_ACC1: begin mul_a = ins_sel;  mul_b = lat_val; end
            ST_ACC2: ram_we = 1'b1;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        if (s_accept) begin
            r_sent <= s_axis_tdata[SENT_W-1:0];
            r_recv <= s_axis_tdata[SENT_W +: RECV_W];
            r_len  <= s_axis_tdata[SENT_W + RECV_W +: LEN_W];
            r_step <= 4'd0;
            r_row  <= ROW_W'(BETA - 1);
            r_col  <= COL_W'(s_axis_tdata[SENT_W + RECV_W +: LEN_W]);
            r_acc  <= 32'd0;
        end

        if (r_state == ST_PRE) begin
            r_step <= r_step + 4'd1;
            case (r_step)
                4'd1: r_mis    <= {1'b0, r_prod[63:33]};
                4'd2: r_ins_m  <= q31(r_prod);
                4'd3: r_pass_x <= q31(r_prod);
                4'd4: r_ins_x  <= q31(r_prod);
                4'd5: r_pass_m <= q31(r_prod);
                4'd6: r_ins_mm <= q31(r_prod);
                4'd7: r_ins_mx <= q31(r_prod);
                4'd8: r_ins_xm <= q31(r_prod);
                4'd9: r_ins_xx <= q31(r_prod);
                default: ;
            endcase
        end

        case (r_state)
            ST_RD2: r_acc <= q31(r_prod);
            ST_ACC1: begin
                if (pass_ok) begin
                    r_acc <= qadd(r_acc, q31(r_prod));
                end
            end
            ST_ACC2: begin
                r_acc <= cell_final;
                if (last_col) begin
                    r_col <= len_c;
                    if (r_row != '0) begin
                        r_row <= r_row - ROW_W'(1);
                    end
                end else begin
                    r_col <= r_col - COL_W'(1);
                end
            end
            default: ;
        endcase

        if (out_load) begin
            r_m_tdata <= r_acc;
            r_m_tuser <= (r_acc >= r_thresh);
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for ids_channel_likelihood: streams sent/received word pairs under several
// register settings and idle patterns and checks every likelihood and flag beat.
// Depends on idscl_pkg and the block's RTL.
module testbench;
    import idscl_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 200;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 92;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [SENT_W-1:0] sent;
        logic [RECV_W-1:0] recv;
        logic [LEN_W-1:0]  len;
        bit                hold;   // wait for all outstanding results before this beat
    } t_word_pair;

    typedef struct {
        logic [31:0] likelihood;
        logic        above;
    } t_lik_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;   // sent[7:0], recv[23:8], len[27:24], zero pad
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;        // likelihood[31:0]
    logic              m_axis_tuser;        // above_threshold[0]

    // Register copies used by the predictor.
    logic [14:0] cfg_indel  = INDEL_RST;
    logic [15:0] cfg_subst  = SUBST_RST;
    logic [31:0] cfg_thresh = THRESH_RST;

    t_word_pair  pair_q[$];
    t_lik_result likelihood_q[$];

    int  n_queued = 0;
    int  n_accepted = 0;
    int  n_checked = 0;
    int  n_errors = 0;
    int  quiet_cycles = 0;
    int  src_idle_pct = 0;
    int  sink_stall_pct = 0;
    bit  in_taken = 1'b0;

    ids_channel_likelihood dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] q31_mul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        return p[62:31];
    endfunction

    function automatic logic [31:0] q31_sum(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > 33'h0_8000_0000)
            return ONE_Q31;
        return s[31:0];
    endfunction

    // Walks the lattice from the last sent symbol back to the first, one row at a time.
    function automatic logic [31:0] channel_likelihood(input logic [SENT_W-1:0] sent,
                                                       input logic [RECV_W-1:0] recv,
                                                       input logic [LEN_W-1:0] len);
        logic [31:0] below [0:MAX_RECV+1];
        logic [31:0] here  [0:MAX_RECV+1];
        logic [14:0] pid;
        logic [15:0] ps;
        logic [31:0] pid31, pass31, ps31, hit31, miss31, acc, s0, s1;
        int          n;
        n = len;
        if (n > MAX_RECV)
            return '0;
        pid    = (cfg_indel > PID_MAX) ? PID_MAX : cfg_indel;
        ps     = (cfg_subst > PS_MAX) ? PS_MAX : cfg_subst;
        pid31  = {1'b0, pid, 16'd0};
        ps31   = {ps, 16'd0};
        pass31 = ONE_Q31 - (pid31 << 1);
        hit31  = ONE_Q31 - ps31;
        miss31 = ps31 / 3;
        for (int j = 0; j <= MAX_RECV + 1; j++) begin
            below[j] = (j == n) ? ONE_Q31 : 32'd0;
            here[j]  = '0;
        end
        for (int i = BETA - 1; i >= 0; i--) begin
            for (int j = 0; j <= n; j++) begin
                acc = q31_mul(pid31, below[j]);
                if (j < n) begin
                    s0  = (sent[2*i +: 2] == recv[2*j +: 2]) ? hit31 : miss31;
                    acc = q31_sum(acc, q31_mul(q31_mul(pass31, s0), below[j+1]));
                    if (j + 1 < n) begin
                        s1  = (sent[2*i +: 2] == recv[2*(j+1) +: 2]) ? hit31 : miss31;
                        acc = q31_sum(acc, q31_mul(q31_mul(q31_mul(pid31, s0), s1),
                                                   below[j+2]));
                    end
                end
                here[j] = acc;
            end
            below = here;
        end
        return below[0];
    endfunction

    // A received word made by running the sent word through random edits.
    function automatic t_word_pair channel_word();
        t_word_pair w;
        int         n, pick;
        logic [1:0] sym, noise;
        w.sent = $urandom;
        w.recv = $urandom;
        w.hold = ($urandom_range(49) == 0);
        n = 0;
        for (int i = 0; i < BETA; i++) begin
            sym  = w.sent[2*i +: 2];
            pick = $urandom_range(9);
            if (pick >= 2) begin
                noise = $urandom;
                w.recv[2*n +: 2] = ($urandom_range(3) == 0) ? noise : sym;
                n++;
                if (pick < 4) begin
                    noise = $urandom;
                    w.recv[2*n +: 2] = noise;
                    n++;
                end
            end
        end
        w.len = n;
        return w;
    endfunction

    function automatic t_word_pair random_word();
        t_word_pair w;
        int         pick;
        w.sent = $urandom;
        w.recv = $urandom;
        w.hold = ($urandom_range(49) == 0);
        pick   = $urandom_range(99);
        if (pick < 65)
            w = channel_word();
        else if (pick < 93)
            w.len = $urandom_range(MAX_RECV);
        else
            w.len = $urandom_range(MAX_RECV + 1, 15);
        return w;
    endfunction

    task automatic add_pair(input logic [SENT_W-1:0] sent, input logic [RECV_W-1:0] recv,
                            input logic [LEN_W-1:0] len, input bit hold);
        t_word_pair w;
        w.sent = sent;
        w.recv = recv;
        w.len  = len;
        w.hold = hold;
        pair_q = {pair_q, w};
        n_queued++;
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_INDEL:  cfg_indel  = data[14:0];
            REG_SUBST:  cfg_subst  = data[15:0];
            REG_THRESH: cfg_thresh = data;
            default: ;
        endcase
    endtask

    // Returns at a rising edge once every queued pair has produced its result.
    task automatic wait_drained();
        do @(negedge i_clk); while (n_checked != n_queued);
        @(posedge i_clk);
    endtask

    // Driver: a new beat goes out only after the previous one was taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            if (pair_q.size() > 0 && !(pair_q[0].hold && likelihood_q.size() != 0)
                    && $urandom_range(99) >= src_idle_pct) begin
                s_axis_tdata  <= {4'd0, pair_q[0].len, pair_q[0].recv, pair_q[0].sent};
                s_axis_tvalid <= 1'b1;
                void'(pair_q.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin : monitor
        t_lik_result want;
        t_lik_result got;
        if (i_rst_n) begin
            in_taken = s_axis_tvalid && s_axis_tready;
            if (in_taken) begin
                want.likelihood = channel_likelihood(s_axis_tdata[7:0], s_axis_tdata[23:8],
                                                     s_axis_tdata[27:24]);
                want.above = (want.likelihood >= cfg_thresh);
                likelihood_q = {likelihood_q, want};
                n_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.likelihood = m_axis_tdata;
                got.above      = m_axis_tuser;
                n_checked++;
                if (likelihood_q.size() == 0) begin
                    $display("%0t: unexpected result beat, likelihood %08h flag %0b",
                             $time, got.likelihood, got.above);
                    n_errors++;
                end else begin
                    want = likelihood_q.pop_front();
                    if (got.likelihood !== want.likelihood) begin
                        $display("%0t: likelihood mismatch, expected %08h, actual %08h",
                                 $time, want.likelihood, got.likelihood);
                        n_errors++;
                    end
                    if (got.above !== want.above) begin
                        $display("%0t: threshold flag mismatch, expected %0b, actual %0b",
                                 $time, want.above, got.above);
                        n_errors++;
                    end
                end
            end
            if (in_taken || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        logic [14:0] indel;
        logic [15:0] subst;
        logic [31:0] thresh;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pairs under the reset settings.
        add_pair(8'h00, 16'h0000, 4'd0, 1'b0);   // empty received word
        add_pair(8'hE4, 16'h00E4, 4'd4, 1'b0);   // exact copy
        add_pair(8'hE4, 16'hFFE4, 4'd4, 1'b0);   // junk above the length is ignored
        add_pair(8'hFF, 16'hFFFF, 4'd8, 1'b0);   // longest word, all symbols equal
        add_pair(8'h00, 16'hFFFF, 4'd8, 1'b0);   // longest word, all mismatched
        add_pair(8'h1B, 16'h0000, 4'd4, 1'b0);
        add_pair(8'hE4, 16'h0024, 4'd3, 1'b0);   // one deletion
        add_pair(8'hE4, 16'h03E4, 4'd5, 1'b0);   // one insertion
        add_pair(8'hE4, 16'h0000, 4'd1, 1'b0);
        add_pair(8'h55, 16'h5555, 4'd8, 1'b0);   // every symbol doubled
        add_pair(8'hAA, 16'h000A, 4'd2, 1'b0);
        add_pair(8'hE4, 16'h00E4, 4'd9, 1'b0);   // length just past the maximum
        add_pair(8'hFF, 16'hFFFF, 4'd15, 1'b0);  // largest length field
        add_pair(8'h00, 16'h0000, 4'd12, 1'b0);
        add_pair(8'h5A, 16'h6A5A, 4'd6, 1'b0);
        add_pair(8'h39, 16'h0039, 4'd4, 1'b1);   // sent only after everything has drained
        add_pair(8'hC6, 16'h0C6C, 4'd7, 1'b0);
        add_pair(8'hFF, 16'h0000, 4'd2, 1'b0);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 65; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 65; end
                default: begin src_idle_pct = 33; sink_stall_pct = 33; end
            endcase
            case (ph)
                0: begin indel = 15'd0;       subst = 16'd0;      thresh = 32'd0;   end
                1: begin indel = PID_MAX;     subst = PS_MAX;     thresh = ONE_Q31; end
                2: begin indel = 15'h7FFF;    subst = 16'hFFFF;   thresh = 32'd1;   end
                3: begin indel = 15'd4096;    subst = 16'd8192;   thresh = ONE_Q31 >> 10; end
                5: begin indel = PID_MAX + 1; subst = PS_MAX + 1; thresh = ONE_Q31 >> 1; end
                7: begin indel = 15'd1;       subst = 16'd1;      thresh = 32'h7FFF_FFFF; end
                default: begin
                    indel  = $urandom_range(0, 16400);
                    subst  = $urandom_range(0, 32800);
                    thresh = ONE_Q31 >> $urandom_range(0, 31);
                end
            endcase
            apb_write(REG_INDEL, {17'd0, indel});
            apb_write(REG_SUBST, {16'd0, subst});
            apb_write(REG_THRESH, thresh);
            // An unused register slot must not disturb the others.
            if (ph == 2)
                apb_write(REG_UNUSED, 32'hFFFF_FFFF);
            @(posedge i_clk);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pair_q = {pair_q, random_word()};
                n_queued++;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (likelihood_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, likelihood_q.size());
            n_errors++;
        end
        $display("Sent %0d word pairs through %0d register settings and four idle patterns;",
                 n_accepted, PHASES + 1);
        $display("compared %0d result beats, %0d mismatches found.", n_checked, n_errors);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
